>>> rtl/two_key_sorted_priority_queue_unit_defines.svh
// assertion macros for the two-key sorted priority queue
// used by the top level only; expects clk and rst_n in scope
`ifndef TWO_KEY_SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define TWO_KEY_SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TKPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("priority queue check failed");

// next-cycle implication, checked outside reset
`define TKPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("priority queue check failed");

`endif

>>> rtl/tkpq_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and key helper for the two-key priority queue
// no dependencies
package tkpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TAG_W       = 16;
  localparam int RANK_W      = 2;
  localparam int PRIO_W      = 3;
  localparam int KEY_W       = RANK_W + PRIO_W;
  localparam int FILL_W      = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // per-cycle command to every cell
  typedef struct packed {
    logic insert_en;
    logic remove_en;
  } cell_ctl_t;

  function automatic logic [KEY_W-1:0] key_of(input entry_t e);
    return {e.rank, e.prio};
  endfunction

endpackage

>>> rtl/tkpq_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for requests and results
// depends on tkpq_pkg for field widths
interface tkpq_in_if import tkpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [TAG_W-1:0]  entry_tag;
  logic [RANK_W-1:0] rank_key;
  logic [PRIO_W-1:0] prio_key;

  modport source (output valid, op, entry_tag, rank_key, prio_key, input ready);
  modport sink   (input valid, op, entry_tag, rank_key, prio_key, output ready);
endinterface

interface tkpq_out_if import tkpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [TAG_W-1:0]  out_tag;
  logic [RANK_W-1:0] out_rank;
  logic [PRIO_W-1:0] out_prio;
  logic [FILL_W-1:0] fill_level;

  modport source (output valid, status, out_tag, out_rank, out_prio, fill_level,
                  input ready);
  modport sink   (input valid, status, out_tag, out_rank, out_prio, fill_level,
                  output ready);
endinterface

>>> rtl/tkpq_cell.sv
`timescale 1ns / 1ps
// one slot of the sorted chain: holds an entry, compares against the new key
// depends on tkpq_pkg
module tkpq_cell import tkpq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,
  input  entry_t    new_entry,
  input  logic      prev_keep,
  input  entry_t    prev_entry,
  input  entry_t    next_entry,
  output logic      keep,
  output entry_t    entry
);

  entry_t entry_r;
  entry_t entry_nxt;

  // keep means this slot stays put because its key is not above the new one
  assign keep  = occupied && (key_of(entry_r) <= key_of(new_entry));
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.insert_en) begin
      if (keep) begin
        entry_nxt = entry_r;
      end else if (prev_keep) begin
        entry_nxt = new_entry;
      end else begin
        entry_nxt = prev_entry;
      end
    end else if (ctl.remove_en) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> rtl/two_key_sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// Sorted priority queue built as a row of slot cells, one entry per cell,
// ordered by (rank, priority) with arrival order kept among equal keys.
// Every request (insert or remove) is absorbed by all cells together: they
// compare against the new key in parallel and shift right or left by one.
// One request is taken per cycle; its result appears on the registered
// output in the cycle after the transfer, and a new request is still taken
// while that result waits, as long as the output stage will free up.
// Depth is QUEUE_DEPTH in tkpq_pkg; no clearing pass is needed after reset.
// Depends on tkpq_pkg, tkpq_if, tkpq_cell and the defines header.
`include "two_key_sorted_priority_queue_unit_defines.svh"

module two_key_sorted_priority_queue_unit import tkpq_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  tkpq_in_if.sink     in_ch,
  tkpq_out_if.source  out_ch
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          status_r, status_nxt;
  entry_t           out_entry_r, out_entry_nxt;

  logic      in_fire;
  logic      is_full, is_empty;
  logic      insert_full;
  cell_ctl_t ctl;
  entry_t    new_entry;
  entry_t    cells   [QUEUE_DEPTH];
  logic      keeps   [QUEUE_DEPTH];
  logic      occ     [QUEUE_DEPTH];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty    = (count_r == '0);
  assign insert_full = in_fire && (in_ch.op == OP_INSERT) && is_full;

  assign new_entry.tag  = in_ch.entry_tag;
  assign new_entry.rank = in_ch.rank_key;
  assign new_entry.prio = in_ch.prio_key;

  assign ctl.insert_en = in_fire && (in_ch.op == OP_INSERT) && !is_full;
  assign ctl.remove_en = in_fire && (in_ch.op == OP_REMOVE) && !is_empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_k;

    assign occ[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_head
      assign prev_e = new_entry;
      assign prev_k = 1'b1;
    end else begin : g_body
      assign prev_e = cells[i-1];
      assign prev_k = keeps[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_e = new_entry;
    end else begin : g_inner
      assign next_e = cells[i+1];
    end

    tkpq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ[i]),
      .new_entry  (new_entry),
      .prev_keep  (prev_k),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .keep       (keeps[i]),
      .entry      (cells[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    out_entry_nxt = out_entry_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_entry_nxt = '0;
      if (in_ch.op == OP_INSERT) begin
        if (is_full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          status_nxt = ST_INSERTED;
          count_nxt  = count_r + 1'b1;
        end
      end else begin
        if (is_empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          status_nxt    = ST_REMOVED;
          out_entry_nxt = cells[0];
          count_nxt     = count_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r    <= status_nxt;
    out_entry_r <= out_entry_nxt;
  end

  // fill level follows the count after the transfer that produced the result
  logic [CNT_W-1:0] fill_r, fill_nxt;
  assign fill_nxt = in_fire ? count_nxt : fill_r;

  always_ff @(posedge clk) begin
    fill_r <= fill_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.out_tag    = out_entry_r.tag;
  assign out_ch.out_rank   = out_entry_r.rank;
  assign out_ch.out_prio   = out_entry_r.prio;
  assign out_ch.fill_level = FILL_W'(fill_r);

  `TKPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH))
  `TKPQ_ASSERT_NOW(a_head_sorted, count_r >= CNT_W'(2), key_of(cells[0]) <= key_of(cells[1]))
  `TKPQ_ASSERT_NEXT(a_pop_count, ctl.remove_en, count_r == $past(count_r) - 1'b1)
  `TKPQ_ASSERT_NEXT(a_full_hold, insert_full, count_r == CNT_W'(QUEUE_DEPTH))

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// testbench for two_key_sorted_priority_queue_unit: random insert/remove traffic with
// a scoreboard that mirrors the sorted queue and checks every result in order
// depends on tkpq_pkg, tkpq_if and the rtl top level
module tb_top import tkpq_pkg::*; ();

  localparam int unsigned BLOCKS         = 23;
  localparam int unsigned BLOCK_LEN      = 50;
  localparam int unsigned HOLD_AFTER     = 400;
  localparam int unsigned LONG_HOLD      = 150;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 10;

  typedef struct {
    status_t           status;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
    logic [PRIO_W-1:0] prio;
    logic [FILL_W-1:0] fill;
  } pq_result_t;

  class pq_scoreboard;
    entry_t      held_entries[$];
    pq_result_t  pending_results[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // apply one accepted request to the mirrored queue and queue its result
    function void note_request(logic op, entry_t e);
      pq_result_t        r;
      int unsigned       pos;
      logic [KEY_W-1:0]  new_key;
      r.status = ST_INSERTED;
      r.tag    = '0;
      r.rank   = '0;
      r.prio   = '0;
      new_key  = {e.rank, e.prio};
      if (op == OP_INSERT) begin
        if (held_entries.size() >= QUEUE_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          // equal keys go behind, so arrival order holds among ties
          pos = 0;
          while (pos < held_entries.size() &&
                 {held_entries[pos].rank, held_entries[pos].prio} <= new_key)
            pos++;
          held_entries.insert(pos, e);
        end
      end else if (held_entries.size() == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        r.status = ST_REMOVED;
        r.tag    = held_entries[0].tag;
        r.rank   = held_entries[0].rank;
        r.prio   = held_entries[0].prio;
        void'(held_entries.pop_front());
      end
      r.fill = FILL_W'(held_entries.size());
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      end
    endfunction

    function void check_result(pq_result_t got);
      pq_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d tag %h",
                 $time, got.status, got.tag);
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("out_tag", want.tag, got.tag);
      compare_field("out_rank", want.rank, got.rank);
      compare_field("out_prio", want.prio, got.prio);
      compare_field("fill_level", want.fill, got.fill);
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_idle;

  tkpq_in_if  in_ch ();
  tkpq_out_if out_ch ();

  pq_scoreboard sb = new();

  two_key_sorted_priority_queue_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // offer one request, wait for its transfer, then record it
  task automatic send_request(input logic op, input logic [TAG_W-1:0] tag,
                              input logic [RANK_W-1:0] rank,
                              input logic [PRIO_W-1:0] prio);
    int unsigned gap;
    entry_t      e;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.entry_tag <= tag;
    in_ch.rank_key  <= rank;
    in_ch.prio_key  <= prio;
    do @(posedge clk); while (!in_ch.ready);
    e.tag  = tag;
    e.rank = rank;
    e.prio = prio;
    sb.note_request(op, e);
  endtask

  initial begin : stimulus
    int unsigned       insert_pct;
    logic              op;
    logic [RANK_W-1:0] rank;
    logic [PRIO_W-1:0] prio;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OP_INSERT;
    in_ch.entry_tag <= '0;
    in_ch.rank_key  <= '0;
    in_ch.prio_key  <= '0;
    no_idle = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty remove, key extremes, a three-way tie
    send_request(OP_REMOVE, 16'h0000, 2'd1, 3'd1);
    send_request(OP_INSERT, 16'hFFFF, 2'd3, 3'd5);
    send_request(OP_INSERT, 16'h0000, 2'd1, 3'd1);
    send_request(OP_INSERT, 16'h1234, 2'd0, 3'd0);
    send_request(OP_INSERT, 16'hA5A5, 2'd3, 3'd7);
    send_request(OP_INSERT, 16'h5A5A, 2'd2, 3'd6);
    send_request(OP_INSERT, 16'h0001, 2'd2, 3'd3);
    send_request(OP_INSERT, 16'h0002, 2'd2, 3'd3);
    send_request(OP_INSERT, 16'h0003, 2'd2, 3'd3);
    send_request(OP_INSERT, 16'h8000, 2'd1, 3'd5);
    send_request(OP_INSERT, 16'h7FFF, 2'd3, 3'd1);
    repeat (11) send_request(OP_REMOVE, 16'hFFFF, 2'd3, 3'd7);

    // blocks cycle through fill, balanced, drain and random mixes to hit full and empty often
    for (int unsigned blk = 0; blk < BLOCKS; blk++) begin
      case (blk % 4)
        0: insert_pct = 85;
        1: insert_pct = 50;
        2: insert_pct = 15;
        default: insert_pct = $urandom_range(10, 90);
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      for (int unsigned n = 0; n < BLOCK_LEN; n++) begin
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        if ($urandom_range(0, 9) == 0) begin
          rank = RANK_W'($urandom_range(0, 3));
          prio = PRIO_W'($urandom_range(0, 7));
        end else begin
          rank = RANK_W'($urandom_range(1, 3));
          prio = PRIO_W'($urandom_range(1, 5));
        end
        send_request(op, TAG_W'($urandom_range(0, 65535)), rank, prio);
      end
    end

    in_ch.valid <= 1'b0;
    no_idle = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    int unsigned seen;
    bit          held_off;
    pq_result_t  got;
    out_ch.ready <= 1'b0;
    seen     = 0;
    held_off = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      // one long hold-off lets the queue back up and stall the input side
      if (!held_off && seen == HOLD_AFTER) begin
        stall    = LONG_HOLD;
        held_off = 1'b1;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.status = status_t'(out_ch.status);
      got.tag    = out_ch.out_tag;
      got.rank   = out_ch.out_rank;
      got.prio   = out_ch.out_prio;
      got.fill   = out_ch.fill_level;
      sb.check_result(got);
      seen++;
    end
  end

  // end the run if no transfer happens on either channel for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
